### design/assert_macros.svh
// Assertion macros used by the register write framer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define RWF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same check, evaluated during reset as well.
`define RWF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### design/rwf_pkg.sv
// Package: types, constants and codes of the register write framer.
`timescale 1ns / 1ps
package rwf_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 64;
    localparam int FILL_W      = $clog2(FRAME_BYTES);
    localparam int SUM_W       = FILL_W + 1;

    // Module limit and queue between front and back
    localparam int MAX_MODULES = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_MODULE_COUNT = 1'b0;
    localparam logic CFG_MODULE_KINDS = 1'b1;

    // Command bytes
    localparam logic [7:0] PAD_BYTE    = 8'hff;
    localparam logic [7:0] PREFIX_EXT  = 8'hfe;
    localparam logic [7:0] PREFIX_WIDE = 8'hfc;

    // Request codes
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req_type;

    // Chip kind codes
    typedef enum logic [1:0] {
        KIND_OPNA  = 2'd0,
        KIND_OPN3L = 2'd1,
        KIND_OPM   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // Classified item carried from front to back
    typedef struct packed {
        logic            is_flush;
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_cmd;

    // Queue status toward the front and the back
    typedef struct packed {
        logic              full;
        logic              head_valid;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // Back status, observed at the top level
    typedef struct packed {
        logic              emit;
        logic              frame_end;
        logic              head_valid;
        logic [FILL_W-1:0] fill;
    } t_back_status;

endpackage

### design/rwf_front.sv
// Front: accepts items, remaps and encodes writes, drops absent or reserved ones.
`timescale 1ns / 1ps
module rwf_front (
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_req_type,
    input  logic [2:0]          i_module_index,
    input  logic [15:0]         i_reg_address,
    input  logic [7:0]          i_reg_data,
    input  logic [3:0]          i_module_count,
    input  logic [15:0]         i_module_kinds,
    input  rwf_pkg::t_q_status  i_q,
    output logic                o_push,
    output rwf_pkg::t_cmd       o_cmd
);
    import rwf_pkg::*;

    logic [3:0] eff_count;
    logic [1:0] kind;
    logic [8:0] addr9;
    logic       keep;
    t_cmd       cmd;

    assign o_ready = !i_q.full;

    always_comb begin
        // Module count clamps at the supported maximum
        eff_count = (i_module_count > 4'(MAX_MODULES)) ? 4'(MAX_MODULES) : i_module_count;
        kind      = i_module_kinds[{i_module_index, 1'b0} +: 2];
        addr9     = i_reg_address[8:0];
        keep      = 1'b0;
        cmd       = '0;

        if (i_req_type == REQ_FLUSH) begin
            cmd.is_flush = 1'b1;
            keep         = 1'b1;
        end else if ({1'b0, i_module_index} < eff_count) begin
            if (i_reg_address[15:9] == '0) begin
                // Remap by chip kind
                case (kind)
                    KIND_OPNA, KIND_OPN3L: begin
                        if (addr9 inside {[9'h100:9'h110]}) addr9 = addr9 - 9'h040;
                    end
                    KIND_OPM: begin
                        if (addr9 inside {[9'h0fc:9'h0ff]}) addr9 = addr9 - 9'h0e0;
                    end
                    default: ;
                endcase
                // Short and extended forms; reserved ranges are dropped
                if (addr9 < 9'h0fc) begin
                    cmd.len      = 3'd2;
                    cmd.bytes[0] = addr9[7:0];
                    cmd.bytes[1] = i_reg_data;
                    keep         = 1'b1;
                end else if (addr9 inside {[9'h100:9'h1fb]}) begin
                    cmd.len      = 3'd3;
                    cmd.bytes[0] = PREFIX_EXT;
                    cmd.bytes[1] = addr9[7:0];
                    cmd.bytes[2] = i_reg_data;
                    keep         = 1'b1;
                end
            end else begin
                // Wide form
                cmd.len      = 3'd4;
                cmd.bytes[0] = PREFIX_WIDE;
                cmd.bytes[1] = i_reg_address[15:8];
                cmd.bytes[2] = i_reg_address[7:0];
                cmd.bytes[3] = i_reg_data;
                keep         = 1'b1;
            end
        end
    end

    assign o_push = i_valid && !i_q.full && keep;
    assign o_cmd  = cmd;

endmodule

### design/rwf_queue.sv
// Queue: short FIFO of classified items between front and back.
`timescale 1ns / 1ps
module rwf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rwf_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output rwf_pkg::t_cmd      o_head,
    output rwf_pkg::t_q_status o_status
);
    import rwf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign do_push = i_push && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    assign o_head              = r_mem[r_rd_ptr];
    assign o_status.full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.head_valid = (r_count != '0);
    assign o_status.count      = r_count;

endmodule

### design/rwf_back.sv
// Back: packs queued commands into frames, pads, drives the byte output register.
`timescale 1ns / 1ps
module rwf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rwf_pkg::t_cmd         i_head,
    input  rwf_pkg::t_q_status    i_q,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_frame_end,
    output logic                  o_last,
    output rwf_pkg::t_back_status o_status
);
    import rwf_pkg::*;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [1:0]        r_pos, n_pos;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_frame_end;
    logic              r_out_last;

    logic              step;
    logic              emit;
    logic              done;
    logic              cmd_byte;
    logic              at_end;
    logic              no_room;
    logic [7:0]        byte_val;

    assign step    = !r_out_valid || i_ready;
    assign at_end  = (r_fill == FILL_W'(FRAME_BYTES - 1));
    assign no_room = (SUM_W'(r_fill) + SUM_W'(i_head.len)) > SUM_W'(FRAME_BYTES);

    // Pick the next byte: pad, command byte, or nothing
    always_comb begin
        emit     = 1'b0;
        done     = 1'b0;
        cmd_byte = 1'b0;
        byte_val = PAD_BYTE;
        if (i_q.head_valid) begin
            if (i_head.is_flush) begin
                if (r_fill != '0) begin
                    emit = 1'b1;
                    done = at_end;
                end else begin
                    done = 1'b1;
                end
            end else if (r_pos == '0 && r_fill != '0 && no_room) begin
                emit = 1'b1;
            end else begin
                emit     = 1'b1;
                cmd_byte = 1'b1;
                byte_val = i_head.bytes[r_pos];
                done     = ({1'b0, r_pos} == i_head.len - 3'd1);
            end
        end
    end

    // Frame position and byte index
    always_comb begin
        n_fill = r_fill;
        n_pos  = r_pos;
        if (step && emit) n_fill = at_end ? '0 : r_fill + 1'b1;
        if (step && done) n_pos = '0;
        else if (step && cmd_byte) n_pos = r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_pos  <= n_pos;
            if (step) r_out_valid <= emit;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_byte      <= byte_val;
            r_out_frame_end <= at_end;
            r_out_last      <= done;
        end
    end

    assign o_pop       = step && done;
    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_frame_end;
    assign o_last      = r_out_last;

    assign o_status.emit       = step && emit;
    assign o_status.frame_end  = at_end;
    assign o_status.head_valid = i_q.head_valid;
    assign o_status.fill       = r_fill;

endmodule

### design/register_write_framer_unit.sv
// Top level: register write framer with config registers, front, queue and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// - Input channel (i_in_valid / o_in_ready): one item is a register write
//   (module index, address, data) or a flush. Writes to absent modules and
//   to reserved addresses are taken and produce nothing.
// - Output channel (o_out_valid / i_out_ready): one byte per transfer, with
//   o_frame_end on the 64th byte of a frame and o_last on the final byte
//   caused by an input item. Padding bytes are 0xff.
// - Configuration: i_cfg_we with i_cfg_index selects module_count (0) or
//   module_kinds (1); write only while the block is idle.
// - With the queue empty and no padding due, the first byte of a write passes
//   through the queue and the output register before o_out_valid presents it.
// - Throughput: the back emits one byte per cycle while the receiver is ready;
//   a write yields two to four bytes plus any padding, and a flush pads to the
//   end of a non-empty frame. The single-byte output register sets this rate.
// - A four-entry queue sits between classification and framing, so input
//   items keep being taken while the receiver stalls until the queue fills.
// - Reset (synchronous, active low) empties the queue and the output
//   register, starts an empty frame and clears both config registers.
module register_write_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [2:0]  i_module_index,
    input  logic [15:0] i_reg_address,
    input  logic [7:0]  i_reg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_last
);
    import rwf_pkg::*;

    logic [3:0]   r_module_count;
    logic [15:0]  r_module_kinds;
    logic         push;
    logic         pop;
    t_cmd         front_cmd;
    t_cmd         head;
    t_q_status    q_status;
    t_back_status back_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_count <= '0;
            r_module_kinds <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULE_COUNT: r_module_count <= i_cfg_data[3:0];
                CFG_MODULE_KINDS: r_module_kinds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rwf_front u_front (
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_req_type     (i_req_type),
        .i_module_index (i_module_index),
        .i_reg_address  (i_reg_address),
        .i_reg_data     (i_reg_data),
        .i_module_count (r_module_count),
        .i_module_kinds (r_module_kinds),
        .i_q            (q_status),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    rwf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    rwf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q         (q_status),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_last      (o_last),
        .o_status    (back_status)
    );

    // Checks
    `RWF_ASSERT(a_frame_wrap,
        back_status.emit && back_status.frame_end |=> back_status.fill == '0,
        "frame did not restart after its last byte")
    `RWF_ASSERT(a_emit_has_item, back_status.emit |-> back_status.head_valid,
        "byte emitted with no queued item")
    `RWF_ASSERT(a_pop_has_item, pop |-> q_status.head_valid, "queue popped while empty")
    `RWF_ASSERT(a_queue_bound, q_status.count <= QCNT_W'(QUEUE_DEPTH),
        "queue count beyond depth")
    `RWF_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && q_status.count == '0,
        "reset left output or queue busy")

endmodule
